// ----- design/ille_pkg.sv -----
`default_nettype none

package ille_pkg;

   localparam int CAPACITY = 1024;
   localparam int SLOT_W   = $clog2(CAPACITY);
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int POS_W    = 12;
   localparam int DATA_W   = 32;
   localparam int OP_W     = 3;
   localparam int STAT_W   = 2;
   localparam int LEN_W    = 11;
   localparam int CMP_W    = (COUNT_W >= POS_W) ? COUNT_W + 1 : POS_W;

   localparam logic [OP_W-1:0] OP_READ = 3'd0;
   localparam logic [OP_W-1:0] OP_HEAD = 3'd1;
   localparam logic [OP_W-1:0] OP_TAIL = 3'd2;
   localparam logic [OP_W-1:0] OP_AT   = 3'd3;
   localparam logic [OP_W-1:0] OP_DEL  = 3'd4;

   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   typedef logic [SLOT_W-1:0]  slot_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic signed [POS_W-1:0]  position;
      logic signed [DATA_W-1:0] item_data;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_data;
      logic [STAT_W-1:0]        status;
      logic [LEN_W-1:0]         length;
   } rsp_type;

   typedef struct packed {
      logic     en;
      slot_type addr;
      slot_type link;
   } link_write_type;

endpackage

`default_nettype wire

// ----- design/ille_link_ram.sv -----
`default_nettype none

module ille_link_ram (
   input  wire logic                    clock,
   input  wire ille_pkg::slot_type      rd_addr,
   input  wire ille_pkg::link_write_type wr,
   input  wire ille_pkg::count_type     fill,
   output logic [ille_pkg::SLOT_W-1:0]  rd_link
);

   ille_pkg::slot_type link_mem [ille_pkg::CAPACITY];
   ille_pkg::slot_type rdata_ff;
   ille_pkg::slot_type raddr_ff;
   ille_pkg::slot_type seq_link;
   logic               untouched;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         link_mem[wr.addr] <= wr.link;
      end
      rdata_ff <= link_mem[rd_addr];
      raddr_ff <= rd_addr;
   end

   // slots at or above the fill mark read as linked to the next slot, wrapping at the top
   always_comb begin
      untouched = ille_pkg::COUNT_W'(raddr_ff) >= fill;
      seq_link  = (raddr_ff == ille_pkg::SLOT_W'(ille_pkg::CAPACITY - 1)) ? '0
                                                                         : raddr_ff + 1'b1;
      rd_link   = untouched ? seq_link : rdata_ff;
   end

endmodule

`default_nettype wire

// ----- design/indexed_linked_list_engine.sv -----
// Errors and no-op requests go straight to the response; a read walks to position p,
// an insert or delete at p > 0 walks to the slot before p; head and tail need no walk.
// One request at a time; the longest requests are set by the link walk
// through the link memory's single read port, one slot per cycle.
// Reset (synchronous) empties the list at once; memories are not swept, untouched
// slots are tracked by a fill mark.
`default_nettype none

module indexed_linked_list_engine (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ille_pkg::req_type req_item,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ille_pkg::rsp_type      rsp_item
);

   localparam int SLOT_W  = ille_pkg::SLOT_W;
   localparam int COUNT_W = ille_pkg::COUNT_W;
   localparam int CMP_W   = ille_pkg::CMP_W;
   localparam int DATA_W  = ille_pkg::DATA_W;

   typedef enum logic [3:0] {
      S_IDLE, S_WALK, S_POST, S_VAL,
      S_INS1, S_INS2, S_INS3,
      S_DEL0, S_DEL1, S_DEL2, S_DEL3,
      S_RESP
   } state_type;

   state_type                      state_ff, state_in;
   logic [ille_pkg::OP_W-1:0]      op_ff, op_in;
   logic [DATA_W-1:0]              data_ff, data_in;
   logic                           first_ff, first_in;
   ille_pkg::slot_type             cur_ff, cur_in;
   ille_pkg::count_type            steps_ff, steps_in;
   ille_pkg::slot_type             sslot_ff, sslot_in;
   ille_pkg::slot_type             fnext_ff, fnext_in;
   ille_pkg::slot_type             head_ff, head_in;
   ille_pkg::slot_type             tail_ff, tail_in;
   ille_pkg::slot_type             free_ff, free_in;
   ille_pkg::count_type            count_ff, count_in;
   ille_pkg::count_type            fill_ff, fill_in;
   logic [DATA_W-1:0]              rd_ff, rd_in;
   logic [ille_pkg::STAT_W-1:0]    st_ff, st_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   ille_pkg::rsp_type              rsp_ff, rsp_in;

   ille_pkg::slot_type             lk_ra;
   ille_pkg::link_write_type       lk_wr;
   logic [SLOT_W-1:0]              link_fix;

   logic [DATA_W-1:0]              slot_value_mem [ille_pkg::CAPACITY];
   logic [DATA_W-1:0]              val_rdata_ff;
   ille_pkg::slot_type             val_ra;
   logic                           val_we;

   logic                           pos_neg;
   logic [CMP_W-1:0]               pos_mag;
   logic [CMP_W-1:0]               cnt_c;
   logic                           full;
   logic                           alloc_new;

   ille_link_ram u_link (
      .clock   (clock),
      .rd_addr (lk_ra),
      .wr      (lk_wr),
      .fill    (fill_ff),
      .rd_link (link_fix)
   );

   always_ff @(posedge clock) begin
      if (val_we) begin
         slot_value_mem[free_ff] <= data_ff;
      end
      val_rdata_ff <= slot_value_mem[val_ra];
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      pos_neg   = req_item.position[ille_pkg::POS_W-1];
      pos_mag   = CMP_W'($unsigned(req_item.position));
      cnt_c     = CMP_W'(count_ff);
      full      = (count_ff == COUNT_W'(ille_pkg::CAPACITY));
      alloc_new = (COUNT_W'(free_ff) == fill_ff);

      state_in     = state_ff;
      op_in        = op_ff;
      data_in      = data_ff;
      first_in     = first_ff;
      cur_in       = cur_ff;
      steps_in     = steps_ff;
      sslot_in     = sslot_ff;
      fnext_in     = fnext_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      free_in      = free_ff;
      count_in     = count_ff;
      fill_in      = fill_ff;
      rd_in        = rd_ff;
      st_in        = st_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      lk_ra  = cur_ff;
      lk_wr  = '0;
      val_ra = cur_ff;
      val_we = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_item.op;
               data_in  = req_item.item_data;
               rd_in    = '0;
               st_in    = ille_pkg::ST_DONE;
               first_in = 1'b0;
               cur_in   = head_ff;
               steps_in = '0;
               lk_ra    = head_ff;
               state_in = S_POST;
               priority case (req_item.op)
                  ille_pkg::OP_READ, ille_pkg::OP_DEL: begin
                     if (pos_neg || pos_mag >= cnt_c) begin
                        rd_in    = '1;
                        st_in    = ille_pkg::ST_RANGE;
                        state_in = S_RESP;
                     end else if (req_item.op == ille_pkg::OP_READ) begin
                        steps_in = COUNT_W'(pos_mag);
                        if (pos_mag != '0) state_in = S_WALK;
                     end else if (pos_mag == '0) begin
                        first_in = 1'b1;
                     end else begin
                        steps_in = COUNT_W'(pos_mag - CMP_W'(1));
                        if (pos_mag != CMP_W'(1)) state_in = S_WALK;
                     end
                  end
                  ille_pkg::OP_HEAD: begin
                     if (full) begin
                        st_in    = ille_pkg::ST_FULL;
                        state_in = S_RESP;
                     end else begin
                        first_in = 1'b1;
                     end
                  end
                  ille_pkg::OP_TAIL: begin
                     if (full) begin
                        st_in    = ille_pkg::ST_FULL;
                        state_in = S_RESP;
                     end else if (count_ff == '0) begin
                        first_in = 1'b1;
                     end else begin
                        cur_in = tail_ff;
                     end
                  end
                  ille_pkg::OP_AT: begin
                     if (!pos_neg && pos_mag > cnt_c) begin
                        st_in    = ille_pkg::ST_RANGE;
                        state_in = S_RESP;
                     end else if (full) begin
                        st_in    = ille_pkg::ST_FULL;
                        state_in = S_RESP;
                     end else if (pos_neg || pos_mag == '0) begin
                        first_in = 1'b1;
                     end else begin
                        steps_in = COUNT_W'(pos_mag - CMP_W'(1));
                        if (pos_mag != CMP_W'(1)) state_in = S_WALK;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_WALK: begin
            cur_in   = link_fix;
            lk_ra    = link_fix;
            steps_in = steps_ff - 1'b1;
            if (steps_ff == COUNT_W'(1)) state_in = S_POST;
         end
         S_POST: begin
            priority if (op_ff == ille_pkg::OP_READ) begin
               state_in = S_VAL;
            end else if (op_ff == ille_pkg::OP_DEL) begin
               if (first_ff) begin
                  lk_ra    = head_ff;
                  state_in = S_DEL0;
               end else begin
                  state_in = S_DEL1;
               end
            end else begin
               lk_ra    = free_ff;
               state_in = S_INS1;
            end
         end
         S_VAL: begin
            rd_in    = val_rdata_ff;
            state_in = S_RESP;
         end
         S_INS1: begin
            fnext_in = link_fix;
            if (first_ff) begin
               lk_wr    = '{en: 1'b1, addr: free_ff, link: head_ff};
               val_we   = 1'b1;
               head_in  = free_ff;
               if (count_ff == '0) tail_in = free_ff;
               free_in  = link_fix;
               count_in = count_ff + 1'b1;
               if (alloc_new) fill_in = fill_ff + 1'b1;
               state_in = S_RESP;
            end else begin
               state_in = S_INS2;
            end
         end
         S_INS2: begin
            lk_wr    = '{en: 1'b1, addr: free_ff, link: link_fix};
            val_we   = 1'b1;
            state_in = S_INS3;
         end
         S_INS3: begin
            lk_wr    = '{en: 1'b1, addr: cur_ff, link: free_ff};
            if (cur_ff == tail_ff) tail_in = free_ff;
            free_in  = fnext_ff;
            count_in = count_ff + 1'b1;
            if (alloc_new) fill_in = fill_ff + 1'b1;
            state_in = S_RESP;
         end
         S_DEL0: begin
            head_in  = link_fix;
            if (count_ff == COUNT_W'(1)) tail_in = link_fix;
            lk_wr    = '{en: 1'b1, addr: head_ff, link: free_ff};
            free_in  = head_ff;
            count_in = count_ff - 1'b1;
            state_in = S_RESP;
         end
         S_DEL1: begin
            sslot_in = link_fix;
            lk_ra    = link_fix;
            state_in = S_DEL2;
         end
         S_DEL2: begin
            lk_wr    = '{en: 1'b1, addr: cur_ff, link: link_fix};
            if (sslot_ff == tail_ff) tail_in = cur_ff;
            state_in = S_DEL3;
         end
         S_DEL3: begin
            lk_wr    = '{en: 1'b1, addr: sslot_ff, link: free_ff};
            free_in  = sslot_ff;
            count_in = count_ff - 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = '{read_data: rd_ff, status: st_ff,
                                length: ille_pkg::LEN_W'(count_ff)};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         free_ff      <= '0;
         count_ff     <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff    <= op_in;
      data_ff  <= data_in;
      first_ff <= first_in;
      cur_ff   <= cur_in;
      steps_ff <= steps_in;
      sslot_ff <= sslot_in;
      fnext_ff <= fnext_in;
      rd_ff    <= rd_in;
      st_ff    <= st_in;
      rsp_ff   <= rsp_in;
   end

`ifndef NO_ASSERTIONS
   a_count_fill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= fill_ff && fill_ff <= COUNT_W'(ille_pkg::CAPACITY))
      else $error("list count exceeds fill mark or capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff)) ||
                        (count_ff == $past(count_ff) + 1'b1) ||
                        (count_ff == $past(count_ff) - 1'b1))
      else $error("list count moved by more than one");

   a_full_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == ille_pkg::ST_FULL |->
         rsp_ff.length == ille_pkg::LEN_W'(ille_pkg::CAPACITY))
      else $error("full status with list not at capacity");
`endif

endmodule

`default_nettype wire

// ----- tb/indexed_linked_list_engine_tb.sv -----
`timescale 1ns / 1ps

module indexed_linked_list_engine_tb;

   localparam int LIMIT_CYCLES = 10_000_000;
   localparam int DRAIN_CYCLES = ille_pkg::CAPACITY + 64;
   localparam int LONG_LENGTH  = 120;
   localparam logic [ille_pkg::OP_W-1:0] OP_TOP = {ille_pkg::OP_W{1'b1}};

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   ille_pkg::req_type req_item = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   ille_pkg::rsp_type rsp_item;

   logic [ille_pkg::DATA_W-1:0] list_values[$];
   ille_pkg::rsp_type           expected_rsps[$];

   int cycle_count   = 0;
   int error_count   = 0;
   int sent_count    = 0;
   int checked_count = 0;
   int peak_length   = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   indexed_linked_list_engine u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, expected_rsps.size());
         $display("indexed_linked_list_engine_tb: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // List kept as a plain ordered queue; slot bookkeeping is invisible outside.
   function automatic ille_pkg::rsp_type predict_list_op(input ille_pkg::req_type r);
      ille_pkg::rsp_type res;
      int                p;
      int                count;
      res   = '0;
      p     = int'(r.position);
      count = list_values.size();
      case (r.op)
         ille_pkg::OP_READ, ille_pkg::OP_DEL: begin
            if (p < 0 || p >= count) begin
               res.read_data = '1;
               res.status    = ille_pkg::ST_RANGE;
            end else if (r.op == ille_pkg::OP_READ) begin
               res.read_data = list_values[p];
            end else begin
               list_values.delete(p);
            end
         end
         ille_pkg::OP_HEAD, ille_pkg::OP_TAIL: begin
            if (count >= ille_pkg::CAPACITY)
               res.status = ille_pkg::ST_FULL;
            else if (r.op == ille_pkg::OP_HEAD)
               list_values.push_front(r.item_data);
            else
               list_values.push_back(r.item_data);
         end
         ille_pkg::OP_AT: begin
            if (p > count)
               res.status = ille_pkg::ST_RANGE;
            else if (count >= ille_pkg::CAPACITY)
               res.status = ille_pkg::ST_FULL;
            else
               list_values.insert((p < 0) ? 0 : p, r.item_data);
         end
         default: ;
      endcase
      res.length = ille_pkg::LEN_W'(list_values.size());
      if (list_values.size() > peak_length)
         peak_length = list_values.size();
      return res;
   endfunction

   task automatic send_request(input logic [ille_pkg::OP_W-1:0] op, input int pos,
                               input logic [ille_pkg::DATA_W-1:0] data);
      ille_pkg::req_type r;
      r.op        = op;
      r.position  = pos[ille_pkg::POS_W-1:0];
      r.item_data = data;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_item  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      expected_rsps.push_back(predict_list_op(r));
      sent_count++;
   endtask

   always @(posedge clock) begin : check_rsp
      ille_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         checked_count++;
         if (expected_rsps.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_item.read_data !== want.read_data)
               report_mismatch($sformatf("response %0d read_data %0d, want %0d",
                               checked_count, rsp_item.read_data, want.read_data));
            if (rsp_item.status !== want.status)
               report_mismatch($sformatf("response %0d status %0d, want %0d",
                               checked_count, rsp_item.status, want.status));
            if (rsp_item.length !== want.length)
               report_mismatch($sformatf("response %0d length %0d, want %0d",
                               checked_count, rsp_item.length, want.length));
         end
      end
   end

   task automatic test_directed();
      logic [ille_pkg::OP_W-1:0] op;
      int                        i;
      send_request(ille_pkg::OP_READ, 0, $urandom);
      send_request(ille_pkg::OP_DEL, 0, $urandom);
      send_request(ille_pkg::OP_AT, 1, $urandom);
      send_request(ille_pkg::OP_AT, -2048, 32'd1);
      send_request(ille_pkg::OP_HEAD, 0, 32'h7FFF_FFFF);
      send_request(ille_pkg::OP_TAIL, 0, 32'h8000_0000);
      send_request(ille_pkg::OP_AT, 3, 32'hFFFF_FFFF);
      send_request(ille_pkg::OP_AT, 1, 32'h0000_0000);
      send_request(ille_pkg::OP_AT, 2047, $urandom);
      for (i = 0; i < 5; i++)
         send_request(ille_pkg::OP_READ, i, $urandom);
      send_request(ille_pkg::OP_READ, -1, $urandom);
      send_request(ille_pkg::OP_READ, 2047, $urandom);
      send_request(ille_pkg::OP_READ, 5, $urandom);
      send_request(ille_pkg::OP_DEL, -2048, $urandom);
      send_request(ille_pkg::OP_DEL, 2047, $urandom);
      for (op = ille_pkg::OP_DEL + 1'b1; op != ille_pkg::OP_READ; op++)
         send_request(op, $urandom_range(4095), $urandom);
      send_request(ille_pkg::OP_DEL, 4, $urandom);
      send_request(ille_pkg::OP_DEL, 1, $urandom);
      send_request(ille_pkg::OP_DEL, 0, $urandom);
      send_request(ille_pkg::OP_TAIL, 0, $urandom);
      send_request(ille_pkg::OP_READ, 2, $urandom);
   endtask

   // Long list: far positions force long link walks, then the list drains to empty.
   task automatic test_long_list();
      int n;
      while (list_values.size() < LONG_LENGTH)
         send_request((list_values.size() % 2) ? ille_pkg::OP_HEAD : ille_pkg::OP_TAIL,
                      $urandom_range(4095), $urandom);
      n = list_values.size();
      send_request(ille_pkg::OP_AT, n + 1, $urandom);
      send_request(ille_pkg::OP_AT, n, $urandom);
      send_request(ille_pkg::OP_AT, -2048, $urandom);
      send_request(ille_pkg::OP_AT, 5, $urandom);
      n = list_values.size();
      send_request(ille_pkg::OP_READ, 0, $urandom);
      send_request(ille_pkg::OP_READ, n - 1, $urandom);
      send_request(ille_pkg::OP_READ, n, $urandom);
      send_request(ille_pkg::OP_DEL, n - 1, $urandom);
      send_request(ille_pkg::OP_AT, n - 1, $urandom);
      send_request(ille_pkg::OP_READ, n - 1, $urandom);
      while (list_values.size() > 0) begin
         n = list_values.size();
         send_request(ille_pkg::OP_DEL,
                      ($urandom_range(15) == 0) ? $urandom_range(n - 1, 0) : 0,
                      $urandom);
      end
      send_request(ille_pkg::OP_READ, 0, $urandom);
   endtask

   // Mostly in-range traffic; op weights steer the length toward 6 to 48 entries.
   task automatic test_random(input int n);
      int                          i;
      int                          count;
      int                          pick;
      int                          pos;
      int                          limit;
      int                          w_ins;
      int                          w_del;
      logic [ille_pkg::OP_W-1:0]   op;
      logic [ille_pkg::DATA_W-1:0] data;
      for (i = 0; i < n; i++) begin
         count = list_values.size();
         case ($urandom_range(9))
            0:       data = 32'h7FFF_FFFF;
            1:       data = 32'h8000_0000;
            2:       data = '1;
            3:       data = '0;
            default: data = $urandom;
         endcase
         if ($urandom_range(99) < 8) begin
            op  = ille_pkg::OP_W'($urandom_range(OP_TOP, 0));
            pos = $urandom_range(4095);
         end else begin
            w_ins = (count < 6) ? 65 : (count > 48) ? 15 : 38;
            w_del = (count > 48) ? 45 : (count < 6) ? 15 : 22;
            pick  = $urandom_range(99);
            if (pick < w_ins)
               op = ille_pkg::OP_W'($urandom_range(ille_pkg::OP_AT, ille_pkg::OP_HEAD));
            else if (pick < w_ins + w_del)
               op = ille_pkg::OP_DEL;
            else
               op = ille_pkg::OP_READ;
            limit = (op == ille_pkg::OP_AT) ? count : count - 1;
            if (op == ille_pkg::OP_HEAD || op == ille_pkg::OP_TAIL)
               pos = $urandom_range(4095);
            else if (limit < 0 || $urandom_range(9) == 0)
               pos = $urandom_range(1) ? limit + 1 + $urandom_range(3)
                                       : -1 - $urandom_range(3);
            else
               pos = $urandom_range(limit, 0);
         end
         send_request(op, pos, data);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 6;
      recv_idle_pct = 88;
      test_directed();
      test_random(120);

      send_idle_pct = 88;
      recv_idle_pct = 6;
      test_random(90);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_long_list();
      test_random(70);
      req_valid <= 1'b0;

      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests sent, %0d responses checked, %0d mismatches",
               sent_count, checked_count, error_count);
      $display("list grew to %0d of %0d entries and drained; three back-pressure mixes",
               peak_length, ille_pkg::CAPACITY);
      if (error_count == 0)
         $display("indexed_linked_list_engine_tb: clean");
      else
         $display("indexed_linked_list_engine_tb: errors");
      $finish;
   end

endmodule
